[hw/rtl/e2q_pkg.sv]
package e2q_pkg;

  // fixed-point formats
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int ANGLE_W         = 16;
  localparam int OUT_W           = 16;

  // angle reduction and folding, all in half-angle units
  localparam int HALF_UNIT = 1 << (ANGLE_FRAC_BITS + 1);
  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int R_W       = $clog2(FULL_TURN);
  localparam int D_W       = $clog2(45 * HALF_UNIT + 1);

  // degrees to radians: rad = floor((d * pi + D/2) / D), D = 45 << RAD_SHIFT
  localparam logic [41:0] PI_Q40    = 42'h3243F6A8885;
  localparam int          RAD_SHIFT = ANGLE_FRAC_BITS + 13;
  localparam longint      RAD_BIAS  = (64'd45 << RAD_SHIFT) / 2;
  localparam int          X_W       = 36;
  localparam logic [30:0] RCP45     = 31'((64'd1 << 36) / 45);

  // q30 values
  localparam int          RAD_W   = 30;
  localparam int          T_W     = 31;
  localparam int          SUM_W   = 33;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam int SERIES_TERMS = 7;

  // pipeline depth
  localparam int FRONT_STAGES   = 5;
  localparam int TERM_STAGES    = 4;
  localparam int FINISH_STAGES  = 1;
  localparam int COMBINE_STAGES = 6;
  localparam int LATENCY = FRONT_STAGES + TERM_STAGES * SERIES_TERMS + FINISH_STAGES
                           + COMBINE_STAGES;

  // sin and cos series state for one angle
  typedef struct packed {
    logic                    valid;
    logic                    swap;
    logic                    cneg;
    logic [RAD_W-1:0]        x;
    logic [T_W-1:0]          t_s;
    logic [T_W-1:0]          t_c;
    logic signed [SUM_W-1:0] sum_s;
    logic signed [SUM_W-1:0] sum_c;
  } sc_t;

  // half-angle sine and cosine of one angle
  typedef struct packed {
    logic           valid;
    logic [T_W-1:0] smag;
    logic [T_W-1:0] cmag;
    logic           cneg;
  } ang_t;

  // q30 product back to q30, round half up
  function automatic logic [T_W-1:0] rnd_q30(input logic [61:0] p);
    return T_W'(p[61:30]) + T_W'(p[29]);
  endfunction

endpackage

[hw/rtl/e2q_front.sv]
module e2q_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [e2q_pkg::ANGLE_W-1:0]   angle,
  output e2q_pkg::sc_t                         sc_out
);
  import e2q_pkg::*;

  localparam logic signed [17:0] TURN = 18'(FULL_TURN);
  localparam logic [R_W-1:0] E45  = R_W'(45 * HALF_UNIT);
  localparam logic [R_W-1:0] E90  = R_W'(90 * HALF_UNIT);
  localparam logic [R_W-1:0] E135 = R_W'(135 * HALF_UNIT);
  localparam logic [R_W-1:0] E180 = R_W'(180 * HALF_UNIT);

  logic v1, v2, v3, v4, v5;
  logic [R_W-1:0] r1;
  logic [D_W-1:0] d2;
  logic sw2, cn2, sw3, cn3, sw4, cn4, sw5, cn5;
  logic [X_W-1:0] x3, x4;
  logic [62:0] p4;
  logic [RAD_W-1:0] rad5;

  logic signed [17:0] a_ext, a_lo, a_red;
  logic [R_W-1:0] d_wide;
  logic [D_W-1:0] d_next;
  logic sw_next, cn_next;
  logic [55:0] n_next;
  logic [30:0] q0;
  logic [36:0] rem_w;
  logic [7:0] rem;
  logic [30:0] rad_next;

  // reduce modulo a full turn into [0, turn)
  always_comb begin
    a_ext = 18'(angle);
    a_lo  = a_ext + TURN;
    if (a_ext < 0) begin
      a_red = (a_lo < 0) ? a_lo + TURN : a_lo;
    end else begin
      a_red = (a_ext >= TURN) ? a_ext - TURN : a_ext;
    end
  end

  // fold half angle onto [0, 45] degrees
  always_comb begin
    sw_next = 1'b0;
    cn_next = 1'b0;
    if (r1 <= E45) begin
      d_wide = r1;
    end else if (r1 <= E90) begin
      d_wide  = E90 - r1;
      sw_next = 1'b1;
    end else if (r1 <= E135) begin
      d_wide  = r1 - E90;
      sw_next = 1'b1;
      cn_next = 1'b1;
    end else begin
      d_wide  = E180 - r1;
      cn_next = 1'b1;
    end
    d_next = D_W'(d_wide);
  end

  // scale by pi, pre-divide by the power of two
  assign n_next = 56'(d2) * 56'(PI_Q40) + 56'(RAD_BIAS);

  // reciprocal quotient by 45 with up to two corrections
  always_comb begin
    q0       = p4[62:32];
    rem_w    = 37'(x4) - 37'(q0) * 37'(45);
    rem      = rem_w[7:0];
    rad_next = q0 + 31'(rem >= 8'd45) + 31'(rem >= 8'd90);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    r1   <= a_red[R_W-1:0];
    d2   <= d_next;
    sw2  <= sw_next;
    cn2  <= cn_next;
    x3   <= n_next[RAD_SHIFT +: X_W];
    sw3  <= sw2;
    cn3  <= cn2;
    p4   <= 63'(x3[X_W-1:4]) * 63'(RCP45);
    x4   <= x3;
    sw4  <= sw3;
    cn4  <= cn3;
    rad5 <= rad_next[RAD_W-1:0];
    sw5  <= sw4;
    cn5  <= cn4;
  end

  always_comb begin
    sc_out.valid = v5;
    sc_out.swap  = sw5;
    sc_out.cneg  = cn5;
    sc_out.x     = rad5;
    sc_out.t_s   = T_W'(rad5);
    sc_out.t_c   = ONE_Q30;
    sc_out.sum_s = '0;
    sc_out.sum_c = '0;
  end

endmodule

[hw/rtl/e2q_term.sv]
module e2q_term #(
  parameter int K = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  e2q_pkg::sc_t sc_in,
  output e2q_pkg::sc_t sc_out
);
  import e2q_pkg::*;

  localparam int          SDIV     = (2 * K) * (2 * K + 1);
  localparam int          CDIV     = (2 * K - 1) * (2 * K);
  localparam logic [31:0] SRCP     = 32'((64'd1 << 32) / SDIV);
  localparam logic [31:0] CRCP     = 32'((64'd1 << 32) / CDIV);
  localparam bit          PREV_NEG = ((K - 1) % 2) == 1;

  logic v1, v2, v3, v4;
  logic sw1, sw2, sw3, sw4, cn1, cn2, cn3, cn4;
  logic [RAD_W-1:0] x1, x2, x3, x4;
  logic signed [SUM_W-1:0] ss1, ss2, ss3, ss4, sc1, sc2, sc3, sc4;
  logic [60:0] ps1, pc1, ps2, pc2;
  logic [T_W-1:0] ts3, tc3, ts4, tc4;
  logic [62:0] ps3, pc3;

  logic signed [SUM_W-1:0] ts_in, tc_in;
  logic [T_W-1:0] ts_r1, tc_r1, ts_r2, tc_r2;
  logic [30:0] qs0, qc0;
  logic [39:0] rems, remc;

  // fold the previous term into the running sums
  assign ts_in = $signed({2'b00, sc_in.t_s});
  assign tc_in = $signed({2'b00, sc_in.t_c});

  assign ts_r1 = rnd_q30(62'(ps1));
  assign tc_r1 = rnd_q30(62'(pc1));
  assign ts_r2 = rnd_q30(62'(ps2));
  assign tc_r2 = rnd_q30(62'(pc2));

  // divide by the factorial factors, one correction step
  always_comb begin
    qs0  = ps3[62:32];
    qc0  = pc3[62:32];
    rems = 40'(ts3) - 40'(qs0) * 40'(SDIV);
    remc = 40'(tc3) - 40'(qc0) * 40'(CDIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= sc_in.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // t * x
    ps1 <= 61'(sc_in.t_s) * 61'(sc_in.x);
    pc1 <= 61'(sc_in.t_c) * 61'(sc_in.x);
    ss1 <= PREV_NEG ? sc_in.sum_s - ts_in : sc_in.sum_s + ts_in;
    sc1 <= PREV_NEG ? sc_in.sum_c - tc_in : sc_in.sum_c + tc_in;
    x1  <= sc_in.x;
    sw1 <= sc_in.swap;
    cn1 <= sc_in.cneg;
    // second multiply by x
    ps2 <= 61'(ts_r1) * 61'(x1);
    pc2 <= 61'(tc_r1) * 61'(x1);
    ss2 <= ss1;
    sc2 <= sc1;
    x2  <= x1;
    sw2 <= sw1;
    cn2 <= cn1;
    // reciprocal multiply
    ts3 <= ts_r2;
    tc3 <= tc_r2;
    ps3 <= 63'(ts_r2) * 63'(SRCP);
    pc3 <= 63'(tc_r2) * 63'(CRCP);
    ss3 <= ss2;
    sc3 <= sc2;
    x3  <= x2;
    sw3 <= sw2;
    cn3 <= cn2;
    // corrected quotient
    ts4 <= qs0 + 31'(rems >= 40'(SDIV));
    tc4 <= qc0 + 31'(remc >= 40'(CDIV));
    ss4 <= ss3;
    sc4 <= sc3;
    x4  <= x3;
    sw4 <= sw3;
    cn4 <= cn3;
  end

  always_comb begin
    sc_out.valid = v4;
    sc_out.swap  = sw4;
    sc_out.cneg  = cn4;
    sc_out.x     = x4;
    sc_out.t_s   = ts4;
    sc_out.t_c   = tc4;
    sc_out.sum_s = ss4;
    sc_out.sum_c = sc4;
  end

endmodule

[hw/rtl/e2q_sincos.sv]
module e2q_sincos (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output e2q_pkg::ang_t                      ang
);
  import e2q_pkg::*;

  localparam bit LAST_NEG = (SERIES_TERMS % 2) == 1;

  sc_t chain [SERIES_TERMS+1];

  logic fv;
  logic [T_W-1:0] s_mag, c_mag;
  logic fcn;
  logic signed [SUM_W-1:0] s_sum, c_sum, ts_l, tc_l;

  e2q_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .angle    (angle),
    .sc_out   (chain[0])
  );

  // one cell per series term
  for (genvar k = 1; k <= SERIES_TERMS; k++) begin : g_term
    e2q_term #(.K(k)) u_term (
      .clk    (clk),
      .rst    (rst),
      .sc_in  (chain[k-1]),
      .sc_out (chain[k])
    );
  end

  // add the last term, then unfold
  always_comb begin
    ts_l  = $signed({2'b00, chain[SERIES_TERMS].t_s});
    tc_l  = $signed({2'b00, chain[SERIES_TERMS].t_c});
    s_sum = LAST_NEG ? chain[SERIES_TERMS].sum_s - ts_l : chain[SERIES_TERMS].sum_s + ts_l;
    c_sum = LAST_NEG ? chain[SERIES_TERMS].sum_c - tc_l : chain[SERIES_TERMS].sum_c + tc_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= chain[SERIES_TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    s_mag <= chain[SERIES_TERMS].swap ? c_sum[T_W-1:0] : s_sum[T_W-1:0];
    c_mag <= chain[SERIES_TERMS].swap ? s_sum[T_W-1:0] : c_sum[T_W-1:0];
    fcn   <= chain[SERIES_TERMS].cneg;
  end

  always_comb begin
    ang.valid = fv;
    ang.smag  = s_mag;
    ang.cmag  = c_mag;
    ang.cneg  = fcn;
  end

endmodule

[hw/rtl/e2q_combine.sv]
module e2q_combine (
  input  logic                              clk,
  input  logic                              rst,
  input  e2q_pkg::ang_t                     ax,
  input  e2q_pkg::ang_t                     ay,
  input  e2q_pkg::ang_t                     az,
  output logic                              out_valid,
  output logic signed [e2q_pkg::OUT_W-1:0]  qx,
  output logic signed [e2q_pkg::OUT_W-1:0]  qy,
  output logic signed [e2q_pkg::OUT_W-1:0]  qz,
  output logic signed [e2q_pkg::OUT_W-1:0]  qw
);
  import e2q_pkg::*;

  localparam int          SH    = 30 - OUT_FRAC_BITS;
  localparam logic [33:0] RND   = (SH > 0) ? 34'(64'd1 << (SH - 1)) : 34'd0;
  localparam logic [33:0] O_ONE = 34'(64'd1 << OUT_FRAC_BITS);

  logic v1, v2, v3, v4, v5, v6;

  // pair products: sx*cy, cx*sy, cx*cy, sx*sy
  logic [61:0] pp [4];
  logic        pn [4];
  logic [T_W-1:0] sz1, cz1;
  logic czn1;
  logic [61:0] tp [8];
  logic        tn [8];
  logic signed [31:0] st [8];
  logic signed [32:0] sv [4];
  logic [33:0] m5 [4];
  logic        n5 [4];
  logic [OUT_W-1:0] o6 [4];

  logic [T_W-1:0] pr [4];
  logic [T_W-1:0] tr [8];
  logic [32:0] av [4];
  logic [33:0] ms [4];
  logic [33:0] mc [4];
  logic [33:0] on [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pr[i] = rnd_q30(pp[i]);
    end
    for (int i = 0; i < 8; i++) begin
      tr[i] = rnd_q30(tp[i]);
    end
    for (int i = 0; i < 4; i++) begin
      av[i] = sv[i][32] ? 33'(-sv[i]) : 33'(sv[i]);
      ms[i] = 34'(av[i]) + RND;
      mc[i] = (m5[i] > O_ONE) ? O_ONE : m5[i];
      on[i] = n5[i] ? 34'd0 - mc[i] : mc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v1 <= ax.valid & ay.valid & az.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    // first products on magnitudes
    pp[0] <= 62'(ax.smag) * 62'(ay.cmag);
    pp[1] <= 62'(ax.cmag) * 62'(ay.smag);
    pp[2] <= 62'(ax.cmag) * 62'(ay.cmag);
    pp[3] <= 62'(ax.smag) * 62'(ay.smag);
    pn[0] <= ay.cneg;
    pn[1] <= ax.cneg;
    pn[2] <= ax.cneg ^ ay.cneg;
    pn[3] <= 1'b0;
    sz1   <= az.smag;
    cz1   <= az.cmag;
    czn1  <= az.cneg;
    // triple products
    tp[0] <= 62'(pr[0]) * 62'(cz1);
    tp[1] <= 62'(pr[1]) * 62'(sz1);
    tp[2] <= 62'(pr[1]) * 62'(cz1);
    tp[3] <= 62'(pr[0]) * 62'(sz1);
    tp[4] <= 62'(pr[2]) * 62'(sz1);
    tp[5] <= 62'(pr[3]) * 62'(cz1);
    tp[6] <= 62'(pr[2]) * 62'(cz1);
    tp[7] <= 62'(pr[3]) * 62'(sz1);
    tn[0] <= pn[0] ^ czn1;
    tn[1] <= pn[1];
    tn[2] <= pn[1] ^ czn1;
    tn[3] <= pn[0];
    tn[4] <= pn[2];
    tn[5] <= pn[3] ^ czn1;
    tn[6] <= pn[2] ^ czn1;
    tn[7] <= pn[3];
    // signed triples
    for (int i = 0; i < 8; i++) begin
      st[i] <= tn[i] ? -$signed({1'b0, tr[i]}) : $signed({1'b0, tr[i]});
    end
    // component sums
    sv[0] <= 33'(st[0]) - 33'(st[1]);
    sv[1] <= 33'(st[2]) + 33'(st[3]);
    sv[2] <= 33'(st[4]) - 33'(st[5]);
    sv[3] <= 33'(st[6]) + 33'(st[7]);
    // round magnitude to output precision
    for (int i = 0; i < 4; i++) begin
      m5[i] <= ms[i] >> SH;
      n5[i] <= sv[i][32];
    end
    // saturate and restore sign
    for (int i = 0; i < 4; i++) begin
      o6[i] <= on[i][OUT_W-1:0];
    end
  end

  assign out_valid = v6;
  assign qx = $signed(o6[0]);
  assign qy = $signed(o6[1]);
  assign qz = $signed(o6[2]);
  assign qw = $signed(o6[3]);

endmodule

[hw/rtl/euler_to_quaternion_unit.sv]
// Euler angles to unit quaternion.
// Input: pulse start with x_angle, y_angle, z_angle (signed degrees, 6 fraction
// bits); a transaction is taken on every clock edge with start high and busy
// low. busy is always low, so a new angle triple can enter every cycle.
// Output: done is high for exactly one cycle with quat_x, quat_y, quat_z,
// quat_w (signed Q1.14) valid in that cycle; the receiver cannot hold results.
// Path: a taken transaction passes angle reduction and radian scaling, then
// one series cell per term for seven terms, then the series finish, then the
// products and output rounding, before its result is shown.
// Throughput: one transaction per cycle; at most one multiplier level per stage.
// Results come out in input order, one per transaction.
// Reset: rst clears every valid bit in the pipeline; transactions in flight are
// dropped and done stays low until new transactions reach the output.
module euler_to_quaternion_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] x_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] y_angle,
  input  logic signed [e2q_pkg::ANGLE_W-1:0] z_angle,
  output logic                               done,
  output logic signed [e2q_pkg::OUT_W-1:0]   quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]   quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]   quat_z,
  output logic signed [e2q_pkg::OUT_W-1:0]   quat_w
);
  import e2q_pkg::*;

  localparam logic signed [OUT_W-1:0] OUT_ONE = OUT_W'(1 << OUT_FRAC_BITS);

  ang_t ang_x, ang_y, ang_z;
  logic accept;

  // fully pipelined, never busy
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // half-angle sin and cos per axis
  e2q_sincos u_sc_x (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .angle    (x_angle),
    .ang      (ang_x)
  );

  e2q_sincos u_sc_y (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .angle    (y_angle),
    .ang      (ang_y)
  );

  e2q_sincos u_sc_z (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .angle    (z_angle),
    .ang      (ang_z)
  );

  // quaternion products and output rounding
  e2q_combine u_combine (
    .clk       (clk),
    .rst       (rst),
    .ax        (ang_x),
    .ay        (ang_y),
    .az        (ang_z),
    .out_valid (done),
    .qx        (quat_x),
    .qy        (quat_y),
    .qz        (quat_z),
    .qw        (quat_w)
  );

  // every result stems from a matching earlier transaction
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // components stay within plus or minus one
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (quat_x <= OUT_ONE && quat_x >= -OUT_ONE && quat_y <= OUT_ONE
              && quat_y >= -OUT_ONE && quat_z <= OUT_ONE && quat_z >= -OUT_ONE
              && quat_w <= OUT_ONE && quat_w >= -OUT_ONE))
    else $error("quaternion component out of range");

  // zero rotation gives the identity quaternion
  a_identity: assert property (@(posedge clk) disable iff (rst)
    (done && $past(start && x_angle == 0 && y_angle == 0 && z_angle == 0, LATENCY))
    |-> (quat_w == OUT_ONE && quat_x == 0 && quat_y == 0 && quat_z == 0))
    else $error("zero angles did not give the identity");

endmodule

[tb/euler_to_quaternion_unit_test.sv]
`timescale 1ns / 1ps

module euler_to_quaternion_unit_test;
  import e2q_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 1425;

  typedef struct packed {
    logic [OUT_W-1:0] qx;
    logic [OUT_W-1:0] qy;
    logic [OUT_W-1:0] qz;
    logic [OUT_W-1:0] qw;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ANGLE_W-1:0] x_angle = '0;
  logic signed [ANGLE_W-1:0] y_angle = '0;
  logic signed [ANGLE_W-1:0] z_angle = '0;
  logic done;
  logic signed [OUT_W-1:0] quat_x, quat_y, quat_z, quat_w;

  quat_t pending_quats[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    idle_pct = 0;

  euler_to_quaternion_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_angle(x_angle), .y_angle(y_angle), .z_angle(z_angle),
    .done(done), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // q30 product on magnitudes, round half away from zero
  function automatic longint q30_mul(longint a, longint b);
    longint p;
    p = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + (64'sd1 <<< 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  function automatic longint q30_sq_step(longint t, longint x);
    t = (t * x + (64'sd1 <<< 29)) >>> 30;
    return (t * x + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // taylor series, odd = sine, even = cosine
  function automatic longint series(longint x, bit is_sin);
    longint t, acc, den;
    t = is_sin ? x : (64'sd1 <<< 30);
    acc = t;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      den = is_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
      t = q30_sq_step(t, x) / den;
      acc = (k & 1) ? acc - t : acc + t;
    end
    return acc;
  endfunction

  function automatic longint half_angle_to_rad(longint d);
    longint div;
    div = 64'sd180 <<< (ANGLE_FRAC_BITS + 11);
    return (d * longint'(PI_Q40) + div / 2) / div;
  endfunction

  // half-angle sine and cosine with quadrant folding
  task automatic half_sin_cos(input logic signed [ANGLE_W-1:0] ang,
                              output longint s, output longint c);
    longint m, r, u, x;
    m = 64'sd360 <<< ANGLE_FRAC_BITS;
    u = 64'sd1 <<< (ANGLE_FRAC_BITS + 1);
    r = longint'(ang) % m;
    if (r < 0) r += m;
    if (r <= 45 * u) begin
      x = half_angle_to_rad(r);
      s = series(x, 1); c = series(x, 0);
    end else if (r <= 90 * u) begin
      x = half_angle_to_rad(90 * u - r);
      s = series(x, 0); c = series(x, 1);
    end else if (r <= 135 * u) begin
      x = half_angle_to_rad(r - 90 * u);
      s = series(x, 0); c = -series(x, 1);
    end else begin
      x = half_angle_to_rad(180 * u - r);
      s = series(x, 1); c = -series(x, 0);
    end
  endtask

  function automatic logic [OUT_W-1:0] to_q14(longint v);
    longint m;
    int sh;
    sh = 30 - OUT_FRAC_BITS;
    m = v < 0 ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    if (m > (64'sd1 <<< OUT_FRAC_BITS)) m = 64'sd1 <<< OUT_FRAC_BITS;
    return OUT_W'(v < 0 ? -m : m);
  endfunction

  function automatic longint trip(longint a, longint b, longint c);
    return q30_mul(q30_mul(a, b), c);
  endfunction

  task automatic predict_quat(input logic signed [ANGLE_W-1:0] ax, ay, az,
                              output quat_t q);
    longint sx, cx, sy, cy, sz, cz;
    half_sin_cos(ax, sx, cx);
    half_sin_cos(ay, sy, cy);
    half_sin_cos(az, sz, cz);
    q.qx = to_q14(trip(sx, cy, cz) - trip(cx, sy, sz));
    q.qy = to_q14(trip(cx, sy, cz) + trip(sx, cy, sz));
    q.qz = to_q14(trip(cx, cy, sz) - trip(sx, sy, cz));
    q.qw = to_q14(trip(cx, cy, cz) + trip(sx, sy, sz));
  endtask

  // present one angle triple and hold until the transaction is taken
  task automatic send_angles(input logic [ANGLE_W-1:0] ax, ay, az);
    quat_t q;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    x_angle <= ax;
    y_angle <= ay;
    z_angle <= az;
    predict_quat(ax, ay, az, q);
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_quats.push_back(q);
  endtask

  task automatic idle_input();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    quat_t want;
    if (!rst && done) begin
      if (pending_quats.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %0d %0d %0d %0d",
                                           quat_x, quat_y, quat_z, quat_w);
      end else begin
        want = pending_quats.pop_front();
        if (want.qx !== quat_x || want.qy !== quat_y ||
            want.qz !== quat_z || want.qw !== quat_w) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: want %0d %0d %0d %0d got %0d %0d %0d %0d",
                     $signed(want.qx), $signed(want.qy), $signed(want.qz),
                     $signed(want.qw), quat_x, quat_y, quat_z, quat_w);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // extremes, folding boundaries and whole turns
  task automatic test_directed();
    logic [ANGLE_W-1:0] pts[12];
    pts = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'd0001,
            16'd5760, 16'd11520, 16'd17280, 16'd23040,
            16'(-23040), 16'd23039, 16'(-5760)};
    for (int i = 0; i < 12; i++) send_angles(pts[i], 16'h0000, 16'h0000);
    for (int i = 0; i < 6; i++) send_angles(16'h0000, pts[i + 6], pts[i]);
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_angles(16'h8000, 16'h8000, 16'h8000);
    send_angles(16'd5760, 16'd5760, 16'd5760);
    send_angles(16'd17280, 16'd11520, 16'(-11520));
    idle_input();
  endtask

  // random angle triples, mostly full range, some near fold points
  task automatic test_random(input int count, input int pct);
    logic [ANGLE_W-1:0] a[3];
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      for (int j = 0; j < 3; j++)
        if ($urandom_range(3) == 0)
          a[j] = ANGLE_W'(5760 * $urandom_range(8) - 23040 + $urandom_range(4) - 2);
        else
          a[j] = ANGLE_W'($urandom);
      send_angles(a[0], a[1], a[2]);
      if ($urandom_range(20) == 0) idle_pct = (idle_pct == 0) ? pct : 0;
    end
    idle_pct = 0;
    idle_input();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(N_RANDOM / 4, 0);
    test_random(N_RANDOM / 4, 75);
    test_random(N_RANDOM / 4, 38);
    test_random(N_RANDOM / 4, 0);
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[files.f]
hw/rtl/e2q_pkg.sv
hw/rtl/e2q_front.sv
hw/rtl/e2q_term.sv
hw/rtl/e2q_sincos.sv
hw/rtl/e2q_combine.sv
hw/rtl/euler_to_quaternion_unit.sv
tb/euler_to_quaternion_unit_test.sv
